[hw/rtl/tlbl_pkg.sv]
package tlbl_pkg;

   // Default sizes of the tree storage
   localparam int NODES_DEFAULT  = 256;
   localparam int LEVELS_DEFAULT = 8;

   // Fixed field widths
   localparam int NODE_W  = 8;
   localparam int DEPTH_W = 8;

   // Datapath operation codes
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE    = 5'd0;
   localparam logic [OP_W-1:0] OP_CLR     = 5'd1;
   localparam logic [OP_W-1:0] OP_LATCH   = 5'd2;
   localparam logic [OP_W-1:0] OP_LD_DRD  = 5'd3;
   localparam logic [OP_W-1:0] OP_LD_L0   = 5'd4;
   localparam logic [OP_W-1:0] OP_LD_RDK  = 5'd5;
   localparam logic [OP_W-1:0] OP_LD_WRK  = 5'd6;
   localparam logic [OP_W-1:0] OP_LD_ROW  = 5'd7;
   localparam logic [OP_W-1:0] OP_LD_ROOT = 5'd8;
   localparam logic [OP_W-1:0] OP_Q_DRD   = 5'd9;
   localparam logic [OP_W-1:0] OP_Q_SWAP  = 5'd10;
   localparam logic [OP_W-1:0] OP_Q1_RD   = 5'd11;
   localparam logic [OP_W-1:0] OP_Q1_DRD  = 5'd12;
   localparam logic [OP_W-1:0] OP_Q1_WR   = 5'd13;
   localparam logic [OP_W-1:0] OP_Q_CMP   = 5'd14;
   localparam logic [OP_W-1:0] OP_Q2_RD   = 5'd15;
   localparam logic [OP_W-1:0] OP_Q2_WR   = 5'd16;
   localparam logic [OP_W-1:0] OP_Q3_WR   = 5'd17;
   localparam logic [OP_W-1:0] OP_OUT     = 5'd18;

   // Controller to datapath
   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_query;  // incoming item is a query
      logic req_root;   // incoming load marks a root
      logic k_zero;     // level counter at level 0
      logic k_last;     // level counter at top level
      logic clr_last;   // clearing pass at last row
      logic a_eq_b;     // lifted nodes are equal
      logic out_free;   // output register can take a result
   } stat_type;

endpackage

[hw/rtl/tree_lca_binary_lifting_unit.sv]
// Lowest common ancestor over a rooted forest held as a binary-lifting table.
// Request channel (req_*): func 0 loads node/parent (has_parent 0 marks a
// root), func 1 queries node against second_node. Parents load first.
// Response channel (rsp_*): one item per query with ancestor and found;
// loads give none.
// The controller walks the table one memory read per step. A query first lifts
// the deeper node level by level (table read, then depth read), then lifts
// both nodes together; the joint lift is skipped when the first lift meets
// the other node. A parent load fills the levels of the node in order.
// Only one item is worked on at a time; req_stall is high while busy.
// The result sits in an output register: a new item is accepted while it
// waits, and a later query holds in its last cycle until rsp_stall drops.
// After reset a clearing pass over all NODES entries zeroes depths and presence
// bits with req_stall high.
module tree_lca_binary_lifting_unit #(
   parameter int NODES  = tlbl_pkg::NODES_DEFAULT,
   parameter int LEVELS = tlbl_pkg::LEVELS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_func,
   input  logic [tlbl_pkg::NODE_W-1:0] req_node,
   input  logic [tlbl_pkg::NODE_W-1:0] req_parent,
   input  logic                        req_has_parent,
   input  logic [tlbl_pkg::NODE_W-1:0] req_second_node,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [tlbl_pkg::NODE_W-1:0] rsp_ancestor,
   output logic                        rsp_found
);

   tlbl_pkg::cmd_type  cmd;
   tlbl_pkg::stat_type stat;

   // Sequencer
   tlbl_ctrl #(
      .LEVELS (LEVELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Tables and working registers
   tlbl_datapath #(
      .NODES  (NODES),
      .LEVELS (LEVELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_func        (req_func),
      .req_node        (req_node),
      .req_parent      (req_parent),
      .req_has_parent  (req_has_parent),
      .req_second_node (req_second_node),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ancestor    (rsp_ancestor),
      .rsp_found       (rsp_found),
      .cmd             (cmd),
      .stat            (stat)
   );

endmodule

[hw/rtl/tlbl_ctrl.sv]
module tlbl_ctrl #(
   parameter int LEVELS = tlbl_pkg::LEVELS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  tlbl_pkg::stat_type stat,
   output tlbl_pkg::cmd_type  cmd
);

   localparam logic [4:0] S_CLEAR   = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_LD_DRD  = 5'd2;
   localparam logic [4:0] S_LD_L0   = 5'd3;
   localparam logic [4:0] S_LD_RDK  = 5'd4;
   localparam logic [4:0] S_LD_WRK  = 5'd5;
   localparam logic [4:0] S_LD_ROW  = 5'd6;
   localparam logic [4:0] S_LD_ROOT = 5'd7;
   localparam logic [4:0] S_Q_DRD   = 5'd8;
   localparam logic [4:0] S_Q_SWAP  = 5'd9;
   localparam logic [4:0] S_Q1_RD   = 5'd10;
   localparam logic [4:0] S_Q1_DRD  = 5'd11;
   localparam logic [4:0] S_Q1_WR   = 5'd12;
   localparam logic [4:0] S_Q_CMP   = 5'd13;
   localparam logic [4:0] S_Q2_RD   = 5'd14;
   localparam logic [4:0] S_Q2_WR   = 5'd15;
   localparam logic [4:0] S_Q3_RD   = 5'd16;
   localparam logic [4:0] S_Q3_WR   = 5'd17;
   localparam logic [4:0] S_Q_OUT   = 5'd18;

   logic [4:0] state_ff;
   logic [4:0] state_in;

   // Input is taken only when idle
   assign req_stall = (state_ff != S_IDLE);

   // Next state and datapath command
   always_comb begin
      state_in = state_ff;
      cmd.op   = tlbl_pkg::OP_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.op = tlbl_pkg::OP_CLR;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = tlbl_pkg::OP_LATCH;
               if (stat.req_query)     state_in = S_Q_DRD;
               else if (stat.req_root) state_in = S_LD_ROOT;
               else                    state_in = S_LD_DRD;
            end
         end
         S_LD_DRD: begin
            cmd.op   = tlbl_pkg::OP_LD_DRD;
            state_in = S_LD_L0;
         end
         S_LD_L0: begin
            cmd.op   = tlbl_pkg::OP_LD_L0;
            state_in = (LEVELS == 1) ? S_LD_ROW : S_LD_RDK;
         end
         S_LD_RDK: begin
            cmd.op   = tlbl_pkg::OP_LD_RDK;
            state_in = S_LD_WRK;
         end
         S_LD_WRK: begin
            cmd.op   = tlbl_pkg::OP_LD_WRK;
            state_in = stat.k_last ? S_LD_ROW : S_LD_RDK;
         end
         S_LD_ROW: begin
            cmd.op   = tlbl_pkg::OP_LD_ROW;
            state_in = S_IDLE;
         end
         S_LD_ROOT: begin
            cmd.op   = tlbl_pkg::OP_LD_ROOT;
            state_in = S_IDLE;
         end
         S_Q_DRD: begin
            cmd.op   = tlbl_pkg::OP_Q_DRD;
            state_in = S_Q_SWAP;
         end
         S_Q_SWAP: begin
            cmd.op   = tlbl_pkg::OP_Q_SWAP;
            state_in = S_Q1_RD;
         end
         S_Q1_RD: begin
            cmd.op   = tlbl_pkg::OP_Q1_RD;
            state_in = S_Q1_DRD;
         end
         S_Q1_DRD: begin
            cmd.op   = tlbl_pkg::OP_Q1_DRD;
            state_in = S_Q1_WR;
         end
         S_Q1_WR: begin
            cmd.op   = tlbl_pkg::OP_Q1_WR;
            state_in = stat.k_zero ? S_Q_CMP : S_Q1_RD;
         end
         S_Q_CMP: begin
            cmd.op   = tlbl_pkg::OP_Q_CMP;
            state_in = stat.a_eq_b ? S_Q_OUT : S_Q2_RD;
         end
         S_Q2_RD: begin
            cmd.op   = tlbl_pkg::OP_Q2_RD;
            state_in = S_Q2_WR;
         end
         S_Q2_WR: begin
            cmd.op   = tlbl_pkg::OP_Q2_WR;
            state_in = stat.k_zero ? S_Q3_RD : S_Q2_RD;
         end
         S_Q3_RD: begin
            // same reads as the joint lift, at level 0
            cmd.op   = tlbl_pkg::OP_Q2_RD;
            state_in = S_Q3_WR;
         end
         S_Q3_WR: begin
            cmd.op   = tlbl_pkg::OP_Q3_WR;
            state_in = S_Q_OUT;
         end
         S_Q_OUT: begin
            cmd.op = tlbl_pkg::OP_OUT;
            if (stat.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/tlbl_datapath.sv]
module tlbl_datapath #(
   parameter int NODES  = tlbl_pkg::NODES_DEFAULT,
   parameter int LEVELS = tlbl_pkg::LEVELS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_func,
   input  logic [tlbl_pkg::NODE_W-1:0]   req_node,
   input  logic [tlbl_pkg::NODE_W-1:0]   req_parent,
   input  logic                          req_has_parent,
   input  logic [tlbl_pkg::NODE_W-1:0]   req_second_node,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tlbl_pkg::NODE_W-1:0]   rsp_ancestor,
   output logic                          rsp_found,
   input  tlbl_pkg::cmd_type             cmd,
   output tlbl_pkg::stat_type            stat
);

   localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
   localparam int AW = $clog2(NODES * LEVELS);
   localparam int VW = tlbl_pkg::NODE_W;
   localparam int DW = tlbl_pkg::DEPTH_W;
   localparam int FIELD_VALUES = 1 << tlbl_pkg::NODE_W;

   // Table slot of node n, level k
   function automatic logic [AW-1:0] slot(input logic [NW-1:0] n, input logic [LW-1:0] k);
      return AW'(n) * AW'(LEVELS) + AW'(k);
   endfunction

   // Node index wrap, one constant entry per field value
   logic [NW-1:0] wrap_lut [FIELD_VALUES];
   for (genvar g = 0; g < FIELD_VALUES; g++) begin : g_wrap
      assign wrap_lut[g] = NW'(g % NODES);
   end

   // Memories
   logic [DW-1:0]     depth_mem_ff [NODES];
   logic [LEVELS-1:0] pres_mem_ff  [NODES];
   logic [VW-1:0]     anc_mem_ff   [NODES * LEVELS];

   logic              dep_we, dep_re0, dep_re1;
   logic [NW-1:0]     dep_wa, dep_ra0, dep_ra1;
   logic [DW-1:0]     dep_wd;
   logic [DW-1:0]     dep_rd0_ff, dep_rd1_ff;

   logic              pres_we, pres_re0, pres_re1;
   logic [NW-1:0]     pres_wa, pres_ra0, pres_ra1;
   logic [LEVELS-1:0] pres_wd;
   logic [LEVELS-1:0] pres_rd0_ff, pres_rd1_ff;

   logic              anc_we, anc_re0, anc_re1;
   logic [AW-1:0]     anc_wa, anc_ra0, anc_ra1;
   logic [VW-1:0]     anc_wd;
   logic [VW-1:0]     anc_rd0_ff, anc_rd1_ff;

   // Working registers
   logic [NW-1:0]     a_ff, a_in;
   logic [NW-1:0]     b_ff, b_in;
   logic [NW-1:0]     p_ff, p_in;
   logic [NW-1:0]     cur_ff, cur_in;
   logic              cpres_ff, cpres_in;
   logic [LEVELS-1:0] row_ff, row_in;
   logic [DW-1:0]     db_ff, db_in;
   logic [LW-1:0]     k_ff, k_in;
   logic [VW-1:0]     res_ff, res_in;
   logic              fnd_ff, fnd_in;
   logic [NW-1:0]     clr_ff, clr_in;

   logic              rsp_valid_ff;
   logic [VW-1:0]     rsp_ancestor_ff;
   logic              rsp_found_ff;

   // Load step helpers: forward own entries on a self reference
   logic [LW-1:0]     km1;
   logic              fwd, pbit, newpres;
   logic [VW-1:0]     newval;
   logic [DW-1:0]     dep_sat;

   assign km1     = k_ff - LW'(1);
   assign fwd     = (cur_ff == a_ff);
   assign pbit    = fwd ? 1'b1 : pres_rd0_ff[km1];
   assign newpres = cpres_ff & pbit;
   assign newval  = !newpres ? '0 : (fwd ? VW'(cur_ff) : anc_rd0_ff);
   assign dep_sat = (dep_rd0_ff == {DW{1'b1}}) ? dep_rd0_ff : dep_rd0_ff + DW'(1);

   // Status
   assign stat.req_query = req_func;
   assign stat.req_root  = !req_has_parent;
   assign stat.k_zero    = (k_ff == '0);
   assign stat.k_last    = (k_ff == LW'(LEVELS - 1));
   assign stat.clr_last  = (clr_ff == NW'(NODES - 1));
   assign stat.a_eq_b    = (a_ff == b_ff);
   assign stat.out_free  = !rsp_valid_ff || !rsp_stall;

   // Operation decode
   always_comb begin
      dep_we   = 1'b0;
      dep_re0  = 1'b0;
      dep_re1  = 1'b0;
      dep_wa   = a_ff;
      dep_ra0  = a_ff;
      dep_ra1  = b_ff;
      dep_wd   = '0;
      pres_we  = 1'b0;
      pres_re0 = 1'b0;
      pres_re1 = 1'b0;
      pres_wa  = a_ff;
      pres_ra0 = a_ff;
      pres_ra1 = b_ff;
      pres_wd  = '0;
      anc_we   = 1'b0;
      anc_re0  = 1'b0;
      anc_re1  = 1'b0;
      anc_wa   = slot(a_ff, k_ff);
      anc_ra0  = slot(a_ff, k_ff);
      anc_ra1  = slot(b_ff, k_ff);
      anc_wd   = '0;
      a_in     = a_ff;
      b_in     = b_ff;
      p_in     = p_ff;
      cur_in   = cur_ff;
      cpres_in = cpres_ff;
      row_in   = row_ff;
      db_in    = db_ff;
      k_in     = k_ff;
      res_in   = res_ff;
      fnd_in   = fnd_ff;
      clr_in   = clr_ff;
      case (cmd.op)
         tlbl_pkg::OP_CLR: begin
            dep_we  = 1'b1;
            dep_wa  = clr_ff;
            pres_we = 1'b1;
            pres_wa = clr_ff;
            clr_in  = clr_ff + NW'(1);
         end
         tlbl_pkg::OP_LATCH: begin
            a_in = wrap_lut[req_node];
            b_in = wrap_lut[req_second_node];
            p_in = wrap_lut[req_parent];
         end
         tlbl_pkg::OP_LD_DRD: begin
            dep_re0 = 1'b1;
            dep_ra0 = p_ff;
         end
         tlbl_pkg::OP_LD_L0: begin
            // depth is the parent's plus one, saturating; level 0 is the parent
            dep_we   = 1'b1;
            dep_wd   = dep_sat;
            anc_we   = 1'b1;
            anc_wa   = slot(a_ff, '0);
            anc_wd   = VW'(p_ff);
            row_in   = LEVELS'(1);
            cur_in   = p_ff;
            cpres_in = 1'b1;
            k_in     = LW'(1);
         end
         tlbl_pkg::OP_LD_RDK: begin
            pres_re0 = 1'b1;
            pres_ra0 = cur_ff;
            anc_re0  = 1'b1;
            anc_ra0  = slot(cur_ff, km1);
         end
         tlbl_pkg::OP_LD_WRK: begin
            anc_we       = 1'b1;
            anc_wd       = newval;
            row_in[k_ff] = newpres;
            cur_in       = NW'(newval);
            cpres_in     = newpres;
            k_in         = k_ff + LW'(1);
         end
         tlbl_pkg::OP_LD_ROW: begin
            pres_we = 1'b1;
            pres_wd = row_ff;
         end
         tlbl_pkg::OP_LD_ROOT: begin
            dep_we  = 1'b1;
            pres_we = 1'b1;
         end
         tlbl_pkg::OP_Q_DRD: begin
            dep_re0 = 1'b1;
            dep_re1 = 1'b1;
         end
         tlbl_pkg::OP_Q_SWAP: begin
            // deeper node goes to a
            if (dep_rd0_ff < dep_rd1_ff) begin
               a_in  = b_ff;
               b_in  = a_ff;
               db_in = dep_rd0_ff;
            end else begin
               db_in = dep_rd1_ff;
            end
            k_in = LW'(LEVELS - 1);
         end
         tlbl_pkg::OP_Q1_RD: begin
            pres_re0 = 1'b1;
            anc_re0  = 1'b1;
         end
         tlbl_pkg::OP_Q1_DRD: begin
            dep_re0 = 1'b1;
            dep_ra0 = NW'(anc_rd0_ff);
         end
         tlbl_pkg::OP_Q1_WR: begin
            if (pres_rd0_ff[k_ff] && (dep_rd0_ff >= db_ff)) a_in = NW'(anc_rd0_ff);
            if (k_ff != '0) k_in = k_ff - LW'(1);
         end
         tlbl_pkg::OP_Q_CMP: begin
            if (a_ff == b_ff) begin
               res_in = VW'(a_ff);
               fnd_in = 1'b1;
            end
            k_in = LW'(LEVELS - 1);
         end
         tlbl_pkg::OP_Q2_RD: begin
            pres_re0 = 1'b1;
            pres_re1 = 1'b1;
            anc_re0  = 1'b1;
            anc_re1  = 1'b1;
         end
         tlbl_pkg::OP_Q2_WR: begin
            // joint lift only where both exist and differ
            if (pres_rd0_ff[k_ff] && pres_rd1_ff[k_ff] && (anc_rd0_ff != anc_rd1_ff)) begin
               a_in = NW'(anc_rd0_ff);
               b_in = NW'(anc_rd1_ff);
            end
            if (k_ff != '0) k_in = k_ff - LW'(1);
         end
         tlbl_pkg::OP_Q3_WR: begin
            if (pres_rd0_ff[0] && pres_rd1_ff[0] && (anc_rd0_ff == anc_rd1_ff)) begin
               res_in = anc_rd0_ff;
               fnd_in = 1'b1;
            end else begin
               res_in = '0;
               fnd_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Depth memory
   always_ff @(posedge clock) begin
      if (dep_we)  depth_mem_ff[dep_wa] <= dep_wd;
      if (dep_re0) dep_rd0_ff <= depth_mem_ff[dep_ra0];
      if (dep_re1) dep_rd1_ff <= depth_mem_ff[dep_ra1];
   end

   // Presence rows, one bit per level
   always_ff @(posedge clock) begin
      if (pres_we)  pres_mem_ff[pres_wa] <= pres_wd;
      if (pres_re0) pres_rd0_ff <= pres_mem_ff[pres_ra0];
      if (pres_re1) pres_rd1_ff <= pres_mem_ff[pres_ra1];
   end

   // Ancestor table
   always_ff @(posedge clock) begin
      if (anc_we)  anc_mem_ff[anc_wa] <= anc_wd;
      if (anc_re0) anc_rd0_ff <= anc_mem_ff[anc_ra0];
      if (anc_re1) anc_rd1_ff <= anc_mem_ff[anc_ra1];
   end

   // Working registers
   always_ff @(posedge clock) begin
      a_ff     <= a_in;
      b_ff     <= b_in;
      p_ff     <= p_in;
      cur_ff   <= cur_in;
      cpres_ff <= cpres_in;
      row_ff   <= row_in;
      db_ff    <= db_in;
      k_ff     <= k_in;
      // result flags start clear for each query
      if (cmd.op == tlbl_pkg::OP_LATCH) begin
         res_ff <= '0;
         fnd_ff <= 1'b0;
      end else begin
         res_ff <= res_in;
         fnd_ff <= fnd_in;
      end
   end

   // Clearing pass counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.op == tlbl_pkg::OP_OUT) && stat.out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == tlbl_pkg::OP_OUT) && stat.out_free) begin
         rsp_ancestor_ff <= res_ff;
         rsp_found_ff    <= fnd_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_ancestor_ff;
   assign rsp_found    = rsp_found_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;

   localparam int NODE_COUNT  = tlbl_pkg::NODES_DEFAULT;
   localparam int LEVEL_COUNT = tlbl_pkg::LEVELS_DEFAULT;

   // Request function codes
   localparam logic FN_LOAD  = 1'b0;
   localparam logic FN_QUERY = 1'b1;

   // Where a directed row's expected result comes from
   localparam logic PREDICTED = 1'b0;
   localparam logic TYPED     = 1'b1;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int LONG_HOLD       = 400;
   localparam int LONG_HOLD_AFTER = 40;
   localparam int DRAIN_TAIL      = 80;
   localparam int PRINT_CAP       = 50;

   typedef logic [tlbl_pkg::NODE_W-1:0] node_type;

   typedef struct packed {
      node_type ancestor;
      logic     found;
   } lca_result_type;

   typedef struct packed {
      logic     func;
      node_type node;
      node_type parent;
      logic     has_parent;
      node_type second;
      logic     fixed_exp;
      node_type exp_anc;
      logic     exp_found;
   } dir_row_type;

   localparam int DIR_ROWS = 25;

   // Directed items: extremes, never-loaded nodes, separate trees, self and late reloads
   dir_row_type dir_rows [DIR_ROWS] = '{
      {FN_QUERY, 8'd0,   8'd0,   1'b0, 8'd0,   TYPED,     8'd0,   1'b1},
      {FN_QUERY, 8'd255, 8'd0,   1'b0, 8'd0,   TYPED,     8'd0,   1'b0},
      {FN_LOAD,  8'd0,   8'd0,   1'b0, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd1,   8'd0,   1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd2,   8'd0,   1'b1, 8'd255, PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd255, 8'd1,   1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd128, 8'd255, 1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd128, 8'd0,   1'b0, 8'd2,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd255, 8'd0,   1'b0, 8'd1,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd1,   8'd255, 1'b1, 8'd128, PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd3,   8'd255, 1'b0, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd4,   8'd3,   1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd4,   8'd0,   1'b0, 8'd255, TYPED,     8'd0,   1'b0},
      {FN_QUERY, 8'd255, 8'd0,   1'b0, 8'd255, TYPED,     8'd255, 1'b1},
      {FN_LOAD,  8'd5,   8'd5,   1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd5,   8'd5,   1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd5,   8'd0,   1'b0, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd1,   8'd0,   1'b0, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd128, 8'd0,   1'b0, 8'd2,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd6,   8'd200, 1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd6,   8'd0,   1'b0, 8'd200, PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd0,   8'd255, 1'b0, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd2,   8'd0,   1'b0, 8'd1,   PREDICTED, 8'd0,   1'b0},
      {FN_LOAD,  8'd255, 8'd255, 1'b1, 8'd0,   PREDICTED, 8'd0,   1'b0},
      {FN_QUERY, 8'd255, 8'd0,   1'b0, 8'd128, PREDICTED, 8'd0,   1'b0}
   };

   logic     clock           = 1'b0;
   logic     reset           = 1'b1;
   logic     req_valid       = 1'b0;
   logic     req_stall;
   logic     req_func        = 1'b0;
   node_type req_node        = '0;
   node_type req_parent      = '0;
   logic     req_has_parent  = 1'b0;
   node_type req_second_node = '0;
   logic     rsp_valid;
   logic     rsp_stall       = 1'b0;
   node_type rsp_ancestor;
   logic     rsp_found;

   // Expected result of a directed row, travels with the item
   logic     row_fixed = 1'b0;
   node_type row_anc   = '0;
   logic     row_found = 1'b0;

   lca_result_type lca_expected_q [$];
   int             mismatch_count = 0;
   int             items_sent     = 0;
   int             query_count    = 0;
   int             burst_left     = 0;
   int unsigned    cycle_count    = 0;

   // Predictor copy of the lifting table
   node_type lift_tab [NODE_COUNT][LEVEL_COUNT];
   bit       lift_ok  [NODE_COUNT][LEVEL_COUNT];
   node_type depth_of [NODE_COUNT];

   tree_lca_binary_lifting_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_node        (req_node),
      .req_parent      (req_parent),
      .req_has_parent  (req_has_parent),
      .req_second_node (req_second_node),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_ancestor    (rsp_ancestor),
      .rsp_found       (rsp_found)
   );

   always #5 clock = ~clock;

   // Load one node: depth from parent, then fill the levels in order
   function automatic void load_node_entry(node_type n, node_type p, logic has_p);
      node_type mid;
      if (!has_p) begin
         depth_of[n] = '0;
         for (int k = 0; k < LEVEL_COUNT; k++) begin
            lift_tab[n][k] = '0;
            lift_ok[n][k]  = 1'b0;
         end
         return;
      end
      // depth saturates on a deep chain
      depth_of[n]   = (depth_of[p] == 8'hFF) ? 8'hFF : depth_of[p] + 8'd1;
      lift_tab[n][0] = p;
      lift_ok[n][0]  = 1'b1;
      for (int k = 1; k < LEVEL_COUNT; k++) begin
         if (lift_ok[n][k-1]) begin
            mid            = lift_tab[n][k-1];
            lift_ok[n][k]  = lift_ok[mid][k-1];
            lift_tab[n][k] = lift_ok[n][k] ? lift_tab[mid][k-1] : '0;
         end else begin
            lift_ok[n][k]  = 1'b0;
            lift_tab[n][k] = '0;
         end
      end
   endfunction

   // Lowest common ancestor: level the depths, then lift both together
   function automatic lca_result_type predict_lca(node_type a_in, node_type b_in);
      node_type       a, b, t, na, nb;
      lca_result_type r;
      a = a_in;
      b = b_in;
      if (depth_of[a] < depth_of[b]) begin
         t = a;
         a = b;
         b = t;
      end
      for (int k = LEVEL_COUNT - 1; k >= 0; k--) begin
         if (lift_ok[a][k] && depth_of[lift_tab[a][k]] >= depth_of[b])
            a = lift_tab[a][k];
      end
      if (a == b) begin
         r.ancestor = a;
         r.found    = 1'b1;
         return r;
      end
      // a level is taken only when both ancestors exist and differ
      for (int k = LEVEL_COUNT - 1; k >= 0; k--) begin
         if (lift_ok[a][k] && lift_ok[b][k] && lift_tab[a][k] != lift_tab[b][k]) begin
            na = lift_tab[a][k];
            nb = lift_tab[b][k];
            a  = na;
            b  = nb;
         end
      end
      if (lift_ok[a][0] && lift_ok[b][0] && lift_tab[a][0] == lift_tab[b][0]) begin
         r.ancestor = lift_tab[a][0];
         r.found    = 1'b1;
      end else begin
         r.ancestor = '0;
         r.found    = 1'b0;
      end
      return r;
   endfunction

   function automatic node_type rand_node();
      return node_type'($urandom);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (mismatch_count < PRINT_CAP)
         $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Offer one item, hold it until taken, then maybe idle between bursts
   task automatic offer_item(logic func, node_type n, node_type p, logic has_p,
                             node_type second, logic fixed_exp, node_type exp_anc,
                             logic exp_found);
      int gap;
      req_valid       <= 1'b1;
      req_func        <= func;
      req_node        <= n;
      req_parent      <= p;
      req_has_parent  <= has_p;
      req_second_node <= second;
      row_fixed       <= fixed_exp;
      row_anc         <= exp_anc;
      row_found       <= exp_found;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Unused fields of each item get random values
   task automatic offer_load(node_type n, node_type p, logic has_p);
      offer_item(FN_LOAD, n, p, has_p, rand_node(), PREDICTED, '0, 1'b0);
   endtask

   task automatic offer_query(node_type a, node_type b);
      offer_item(FN_QUERY, a, rand_node(), 1'($urandom), b, PREDICTED, '0, 1'b0);
   endtask

   // Sender pauses until every outstanding query has answered
   task automatic await_all_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (lca_expected_q.size() != 0);
   endtask

   // Small random forest, loaded parents first, then queries mostly within it
   task automatic forest_round();
      node_type members [$];
      bit       taken [NODE_COUNT];
      node_type n, a, b;
      int       size;
      size = $urandom_range(3, 24);
      while (members.size() < size) begin
         n = rand_node();
         if (!taken[n]) begin
            taken[n] = 1'b1;
            members.push_back(n);
         end
      end
      foreach (members[i]) begin
         if (i == 0 || $urandom_range(0, 9) == 0)
            offer_load(members[i], rand_node(), 1'b0);
         else
            offer_load(members[i], members[$urandom_range(0, i - 1)], 1'b1);
         if ($urandom_range(0, 5) == 0)
            offer_query(members[i], members[$urandom_range(0, i)]);
      end
      repeat ($urandom_range(size / 2, size * 2)) begin
         a = members[$urandom_range(0, size - 1)];
         case ($urandom_range(0, 9))
            0: begin
               b = a;
            end
            1: begin
               b = rand_node();
            end
            default: begin
               b = members[$urandom_range(0, size - 1)];
            end
         endcase
         if ($urandom_range(0, 1) == 0)
            offer_query(a, b);
         else
            offer_query(b, a);
      end
      // noise: arbitrary loads and queries
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 1) == 0)
            offer_query(rand_node(), rand_node());
         else
            offer_load(rand_node(), rand_node(), 1'($urandom));
      end
   endtask

   // One chain through every node in random order, then one level deeper
   task automatic deep_chain();
      node_type order [NODE_COUNT];
      node_type t;
      int       j;
      for (int i = 0; i < NODE_COUNT; i++)
         order[i] = node_type'(i);
      for (int i = NODE_COUNT - 1; i > 0; i--) begin
         j        = $urandom_range(0, i);
         t        = order[i];
         order[i] = order[j];
         order[j] = t;
      end
      offer_load(order[0], rand_node(), 1'b0);
      for (int i = 1; i < NODE_COUNT; i++) begin
         offer_load(order[i], order[i-1], 1'b1);
         if ($urandom_range(0, 15) == 0)
            offer_query(order[i], order[$urandom_range(0, i)]);
      end
      // depth past the deepest node saturates
      offer_load(order[10], order[NODE_COUNT-1], 1'b1);
      repeat (30)
         offer_query(order[$urandom_range(0, NODE_COUNT - 1)],
                     order[$urandom_range(0, NODE_COUNT - 1)]);
   endtask

   // Accepted request items update the predictor or queue an expectation
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_func == FN_LOAD) begin
            load_node_entry(req_node, req_parent, req_has_parent);
         end else begin
            query_count++;
            if (row_fixed == TYPED)
               lca_expected_q.push_back({row_anc, row_found});
            else
               lca_expected_q.push_back(predict_lca(req_node, req_second_node));
         end
      end
   end

   // Accepted result items against the oldest expectation
   always @(posedge clock) begin : result_check
      lca_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (lca_expected_q.size() == 0) begin
            report_mismatch("unexpected result ancestor", rsp_ancestor, -1);
         end else begin
            want = lca_expected_q.pop_front();
            if (rsp_ancestor !== want.ancestor)
               report_mismatch("ancestor", rsp_ancestor, want.ancestor);
            if (rsp_found !== want.found)
               report_mismatch("found", rsp_found, want.found);
         end
      end
   end

   // Receiver: stall runs of random density, plus one long hold-off
   initial begin : rsp_side
      int pct;
      int run_len;
      bit held;
      held = 1'b0;
      forever begin
         if (!held && query_count >= LONG_HOLD_AFTER) begin
            held = 1'b1;
            @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end
         case ($urandom_range(0, 3))
            0: begin
               pct = 0;
            end
            1: begin
               pct = 30;
            end
            2: begin
               pct = 70;
            end
            default: begin
               pct = 95;
            end
         endcase
         run_len = $urandom_range(4, 60);
         repeat (run_len) begin
            @(posedge clock);
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   // Watchdog
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   // Stimulus: reset, directed rows, random forests, a deep chain, more forests
   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         offer_item(dir_rows[i].func, dir_rows[i].node, dir_rows[i].parent,
                    dir_rows[i].has_parent, dir_rows[i].second, dir_rows[i].fixed_exp,
                    dir_rows[i].exp_anc, dir_rows[i].exp_found);
      await_all_results();
      while (items_sent < 200)
         forest_round();
      await_all_results();
      deep_chain();
      while (items_sent < 500)
         forest_round();
      await_all_results();
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tlbl_pkg.sv
hw/rtl/tlbl_ctrl.sv
hw/rtl/tlbl_datapath.sv
hw/rtl/tree_lca_binary_lifting_unit.sv
tb/testbench.sv
